// ----- design/ps2md_pkg.sv -----
// Shared types, constants and arithmetic helpers for the PS/2 mouse packet decoder.
// Used by ps2md_core, ps2md_evbuf and ps2_mouse_packet_decoder_top; depends on nothing.
package ps2md_pkg;

    localparam int POS_BITS = 16;
    localparam int SW       = POS_BITS + 2;
    localparam int EV_SLOTS = 3;
    localparam int SLOT_W   = $clog2(EV_SLOTS);
    localparam int CNT_W    = $clog2(EV_SLOTS + 1);
    localparam int TDATA_W  = 88;

    localparam logic signed [POS_BITS-1:0] POS_RESET = POS_BITS'(10);
    localparam logic signed [SW-1:0] POS_HI = SW'((64'sd1 <<< (POS_BITS - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] POS_LO = SW'(-(64'sd1 <<< (POS_BITS - 1)));

    localparam logic [1:0] MODE_STD   = 2'd0;
    localparam logic [1:0] MODE_WHEEL = 2'd1;
    localparam logic [1:0] MODE_FIVE  = 2'd2;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_CLAMP  = 2'd1;
    localparam logic [1:0] CFG_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_HEIGHT = 2'd3;

    localparam logic [1:0] BYTE_HDR = 2'd0;
    localparam logic [1:0] BYTE_X   = 2'd1;
    localparam logic [1:0] BYTE_Y   = 2'd2;
    localparam logic [1:0] BYTE_EXT = 2'd3;

    localparam logic [2:0] BTN_LEFT   = 3'd0;
    localparam logic [2:0] BTN_RIGHT  = 3'd1;
    localparam logic [2:0] BTN_MIDDLE = 3'd2;
    localparam logic [2:0] BTN_FOURTH = 3'd3;
    localparam logic [2:0] BTN_FIFTH  = 3'd4;

    localparam logic [3:0] NIB_H_NEG = 4'hE;
    localparam logic [3:0] NIB_V_NEG = 4'hF;
    localparam logic [3:0] NIB_V_POS = 4'h1;
    localparam logic [3:0] NIB_H_POS = 4'h2;

    typedef enum logic [2:0] {
        KIND_DOWN  = 3'd0,
        KIND_UP    = 3'd1,
        KIND_MOVE  = 3'd2,
        KIND_WHEEL = 3'd3,
        KIND_SYNC  = 3'd4
    } t_kind;

    typedef struct packed {
        logic [1:0]  mode;
        logic        clamp;
        logic [12:0] width;
        logic [12:0] height;
    } t_cfg;

    typedef struct packed {
        t_kind              kind;
        logic [2:0]         button_id;
        logic signed [7:0]  delta_a;
        logic signed [7:0]  delta_b;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] wheel_v;
        logic signed [15:0] wheel_h;
        logic [4:0]         buttons;
    } t_event;

    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        logic signed [15:0] r;
        if (v > 17'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -17'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [SW-1:0] clamp_screen(input logic signed [SW-1:0] v,
                                                          input logic [12:0] size);
        logic signed [SW-1:0] top;
        logic signed [SW-1:0] r;
        top = $signed(SW'(size)) - $signed(SW'(1));
        r   = v;
        if (r > top) begin
            r = top;
        end
        if (r[SW-1]) begin
            r = '0;
        end
        return r;
    endfunction

    function automatic logic signed [POS_BITS-1:0] sat_pos(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        r = v;
        if (r > POS_HI) begin
            r = POS_HI;
        end else if (r < POS_LO) begin
            r = POS_LO;
        end
        return r[POS_BITS-1:0];
    endfunction

    function automatic logic signed [15:0] pos_out(input logic signed [POS_BITS-1:0] p);
        logic signed [POS_BITS+15:0] e;
        e = (POS_BITS + 16)'(p);
        return e[15:0];
    endfunction

endpackage

// ----- design/ps2md_core.sv -----
// Packet framing, decoder state and single-pass event generation for one received byte.
// Depends on ps2md_pkg.
module ps2md_core (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_fire,
    input  logic [7:0]                                     i_byte,
    input  ps2md_pkg::t_cfg                                i_cfg,
    output ps2md_pkg::t_event [ps2md_pkg::EV_SLOTS-1:0]    o_events,
    output logic [ps2md_pkg::CNT_W-1:0]                    o_count
);

    logic [1:0]                               r_idx,  n_idx;
    logic                                     r_err,  n_err;
    logic [7:0]                               r_xb,   n_xb;
    logic signed [ps2md_pkg::POS_BITS-1:0]    r_px,   n_px;
    logic signed [ps2md_pkg::POS_BITS-1:0]    r_py,   n_py;
    logic signed [15:0]                       r_wv,   n_wv;
    logic signed [15:0]                       r_wh,   n_wh;
    logic [4:0]                               r_bs,   n_bs;

    logic signed [7:0]                        dx, dy;
    logic signed [ps2md_pkg::SW-1:0]          sum_x, sum_y, cl_x, cl_y;
    logic signed [7:0]                        wv_step, wh_step;
    logic                                     wheel_mode;
    logic [4:0]                               bs0, bs1, bs2;
    logic [ps2md_pkg::EV_SLOTS-1:0]           cv;
    ps2md_pkg::t_event [ps2md_pkg::EV_SLOTS-1:0] cand;
    ps2md_pkg::t_event [ps2md_pkg::EV_SLOTS-1:0] list;
    logic [ps2md_pkg::CNT_W-1:0]              cnt;

    always_comb begin
        dx    = $signed(r_xb);
        dy    = $signed(8'(8'd0 - i_byte));
        sum_x = ps2md_pkg::SW'(r_px) + ps2md_pkg::SW'(dx);
        sum_y = ps2md_pkg::SW'(r_py) + ps2md_pkg::SW'(dy);
        cl_x  = sum_x;
        cl_y  = sum_y;
        if (i_cfg.clamp) begin
            cl_x = ps2md_pkg::clamp_screen(sum_x, i_cfg.width);
            cl_y = ps2md_pkg::clamp_screen(sum_y, i_cfg.height);
        end

        wheel_mode = (i_cfg.mode == ps2md_pkg::MODE_WHEEL) ||
                     (i_cfg.mode == ps2md_pkg::MODE_FIVE);
        wv_step = '0;
        wh_step = '0;
        if (i_cfg.mode == ps2md_pkg::MODE_WHEEL) begin
            wv_step = $signed(i_byte);
        end else if (i_cfg.mode == ps2md_pkg::MODE_FIVE) begin
            unique case (i_byte[3:0])
                ps2md_pkg::NIB_H_NEG: wh_step = -8'sd1;
                ps2md_pkg::NIB_V_NEG: wv_step = -8'sd1;
                ps2md_pkg::NIB_V_POS: wv_step = 8'sd1;
                ps2md_pkg::NIB_H_POS: wh_step = 8'sd1;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_idx = r_idx;
        n_err = r_err;
        n_xb  = r_xb;
        n_px  = r_px;
        n_py  = r_py;
        n_wv  = r_wv;
        n_wh  = r_wh;
        bs0   = r_bs;
        bs1   = r_bs;
        bs2   = r_bs;
        cv    = '0;
        cand  = '0;

        unique case (r_idx)
            ps2md_pkg::BYTE_HDR: begin
                if (!i_byte[3]) begin
                    n_err        = 1'b1;
                    cv[0]        = r_err;
                    cand[0].kind = ps2md_pkg::KIND_SYNC;
                end else begin
                    bs0[0] = i_byte[0];
                    bs1    = bs0;
                    bs1[1] = i_byte[1];
                    bs2    = bs1;
                    bs2[2] = i_byte[2];
                    cv[0]  = i_byte[0] != r_bs[0];
                    cv[1]  = i_byte[1] != r_bs[1];
                    cv[2]  = i_byte[2] != r_bs[2];
                    cand[0].kind      = i_byte[0] ? ps2md_pkg::KIND_DOWN : ps2md_pkg::KIND_UP;
                    cand[0].button_id = ps2md_pkg::BTN_LEFT;
                    cand[1].kind      = i_byte[1] ? ps2md_pkg::KIND_DOWN : ps2md_pkg::KIND_UP;
                    cand[1].button_id = ps2md_pkg::BTN_RIGHT;
                    cand[2].kind      = i_byte[2] ? ps2md_pkg::KIND_DOWN : ps2md_pkg::KIND_UP;
                    cand[2].button_id = ps2md_pkg::BTN_MIDDLE;
                    n_idx = ps2md_pkg::BYTE_X;
                end
            end
            ps2md_pkg::BYTE_X: begin
                n_xb  = i_byte;
                n_idx = ps2md_pkg::BYTE_Y;
            end
            ps2md_pkg::BYTE_Y: begin
                if (dx != 8'sd0 || dy != 8'sd0) begin
                    n_px            = ps2md_pkg::sat_pos(cl_x);
                    n_py            = ps2md_pkg::sat_pos(cl_y);
                    cv[0]           = 1'b1;
                    cand[0].kind    = ps2md_pkg::KIND_MOVE;
                    cand[0].delta_a = dx;
                    cand[0].delta_b = dy;
                end
                n_idx = wheel_mode ? ps2md_pkg::BYTE_EXT : ps2md_pkg::BYTE_HDR;
            end
            ps2md_pkg::BYTE_EXT: begin
                n_idx = ps2md_pkg::BYTE_HDR;
                if (wv_step != 8'sd0 || wh_step != 8'sd0) begin
                    n_wv            = ps2md_pkg::sat16(17'(r_wv) + 17'(wv_step));
                    n_wh            = ps2md_pkg::sat16(17'(r_wh) + 17'(wh_step));
                    cv[0]           = 1'b1;
                    cand[0].kind    = ps2md_pkg::KIND_WHEEL;
                    cand[0].delta_a = wv_step;
                    cand[0].delta_b = wh_step;
                end
                if (i_cfg.mode == ps2md_pkg::MODE_FIVE) begin
                    bs1[3] = i_byte[4];
                    bs2    = bs1;
                    bs2[4] = i_byte[5];
                    cv[1]  = i_byte[4] != r_bs[3];
                    cv[2]  = i_byte[5] != r_bs[4];
                    cand[1].kind      = i_byte[4] ? ps2md_pkg::KIND_DOWN : ps2md_pkg::KIND_UP;
                    cand[1].button_id = ps2md_pkg::BTN_FOURTH;
                    cand[2].kind      = i_byte[5] ? ps2md_pkg::KIND_DOWN : ps2md_pkg::KIND_UP;
                    cand[2].button_id = ps2md_pkg::BTN_FIFTH;
                end
            end
        endcase

        n_bs = bs2;

        for (int i = 0; i < ps2md_pkg::EV_SLOTS; i++) begin
            cand[i].pos_x   = ps2md_pkg::pos_out(n_px);
            cand[i].pos_y   = ps2md_pkg::pos_out(n_py);
            cand[i].wheel_v = n_wv;
            cand[i].wheel_h = n_wh;
        end
        cand[0].buttons = bs0;
        cand[1].buttons = bs1;
        cand[2].buttons = bs2;
    end

    always_comb begin
        list = '0;
        cnt  = '0;
        for (int i = 0; i < ps2md_pkg::EV_SLOTS; i++) begin
            if (cv[i]) begin
                list[cnt[ps2md_pkg::SLOT_W-1:0]] = cand[i];
                cnt = cnt + ps2md_pkg::CNT_W'(1);
            end
        end
    end

    assign o_events = list;
    assign o_count  = cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= ps2md_pkg::BYTE_HDR;
            r_err <= 1'b0;
            r_xb  <= '0;
            r_px  <= ps2md_pkg::POS_RESET;
            r_py  <= ps2md_pkg::POS_RESET;
            r_wv  <= '0;
            r_wh  <= '0;
            r_bs  <= '0;
        end else if (i_fire) begin
            r_idx <= n_idx;
            r_err <= n_err;
            r_xb  <= n_xb;
            r_px  <= n_px;
            r_py  <= n_py;
            r_wv  <= n_wv;
            r_wh  <= n_wh;
            r_bs  <= n_bs;
        end
    end

endmodule

// ----- design/ps2md_evbuf.sv -----
// Result register holding the events of one byte and presenting them one beat at a time.
// Depends on ps2md_pkg.
module ps2md_evbuf (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_load,
    input  ps2md_pkg::t_event [ps2md_pkg::EV_SLOTS-1:0]    i_events,
    input  logic [ps2md_pkg::CNT_W-1:0]                    i_count,
    input  logic                                           i_ready,
    output logic                                           o_valid,
    output ps2md_pkg::t_event                              o_event,
    output logic                                           o_last,
    output logic                                           o_room
);

    ps2md_pkg::t_event [ps2md_pkg::EV_SLOTS-1:0] r_ev;
    logic [ps2md_pkg::SLOT_W-1:0]                r_rd;
    logic [ps2md_pkg::CNT_W-1:0]                 r_rem;
    logic                                        pop;

    assign o_valid = r_rem != '0;
    assign pop     = o_valid && i_ready;
    assign o_last  = r_rem == ps2md_pkg::CNT_W'(1);
    assign o_room  = !o_valid || (o_last && pop);
    assign o_event = r_ev[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
            r_rd  <= '0;
        end else if (i_load) begin
            r_rem <= i_count;
            r_rd  <= '0;
        end else if (pop) begin
            r_rem <= r_rem - ps2md_pkg::CNT_W'(1);
            r_rd  <= r_rd + ps2md_pkg::SLOT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ev <= i_events;
        end
    end

endmodule

// ----- design/ps2_mouse_packet_decoder_top.sv -----
// Flow: an accepted byte waits in the input register until the result register has room;
// it is then decoded and its first event beat is presented from the result register.
// Throughput: one event beat per cycle while the sink is ready; a byte is taken every cycle
// while bytes give at most one event and beats are taken; else it waits for the last beat.
// Reset is synchronous, active low; it clears framing, positions (to 10), wheels and buttons.
// Depends on ps2md_pkg, ps2md_core and ps2md_evbuf.
module ps2_mouse_packet_decoder_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [7:0]                        i_s_tdata,   // rx_byte
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // button_id, delta_a, delta_b, pos_x, pos_y, wheel_v, wheel_h, buttons
    output logic [ps2md_pkg::TDATA_W-1:0]     o_m_tdata,
    output logic [2:0]                        o_m_tuser,   // event_kind
    output logic                              o_m_tlast,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [1:0]                        i_cfg_index,
    input  logic [12:0]                       i_cfg_data
);

    ps2md_pkg::t_cfg                             r_cfg;
    logic                                        r_in_valid;
    logic [7:0]                                  r_in_byte;
    logic                                        fire;
    logic                                        room;
    ps2md_pkg::t_event [ps2md_pkg::EV_SLOTS-1:0] events;
    logic [ps2md_pkg::CNT_W-1:0]                 count;
    ps2md_pkg::t_event                           ev;

    assign o_cfg_ready = 1'b1;
    assign fire        = r_in_valid && room;
    assign o_s_tready  = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode   <= ps2md_pkg::MODE_STD;
            r_cfg.clamp  <= 1'b0;
            r_cfg.width  <= 13'd640;
            r_cfg.height <= 13'd480;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ps2md_pkg::CFG_MODE:   r_cfg.mode   <= i_cfg_data[1:0];
                ps2md_pkg::CFG_CLAMP:  r_cfg.clamp  <= i_cfg_data[0];
                ps2md_pkg::CFG_WIDTH:  r_cfg.width  <= i_cfg_data;
                ps2md_pkg::CFG_HEIGHT: r_cfg.height <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
        end
    end

    ps2md_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_byte   (r_in_byte),
        .i_cfg    (r_cfg),
        .o_events (events),
        .o_count  (count)
    );

    ps2md_evbuf u_evbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .i_events (events),
        .i_count  (count),
        .i_ready  (i_m_tready),
        .o_valid  (o_m_tvalid),
        .o_event  (ev),
        .o_last   (o_m_tlast),
        .o_room   (room)
    );

    assign o_m_tuser = ev.kind;
    assign o_m_tdata = {ev.buttons, ev.wheel_h, ev.wheel_v, ev.pos_y, ev.pos_x,
                        ev.delta_b, ev.delta_a, ev.button_id};

`ifndef SYNTHESIS
    a_drain_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast && !fire) |=> !o_m_tvalid)
        else $error("event beats remain after the last beat of a byte was taken");

    a_byte_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fire) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("waiting input byte was lost or overwritten");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> !fire)
        else $error("new byte decoded while earlier events were still pending");
`endif

endmodule

// ----- dv/tb_ps2_mouse_packet_decoder_top.sv -----
// Self-checking testbench for ps2_mouse_packet_decoder_top: drives PS/2 byte streams under
// random idling and stalls and checks every event beat against an in-bench decoder model.
// Depends on ps2md_pkg and ps2_mouse_packet_decoder_top.
module tb_ps2_mouse_packet_decoder_top;

    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 5000;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        ps2md_pkg::t_event ev;
        logic              last;
    } t_mouse_event;

    typedef struct {
        logic [7:0] data;
        bit         hold;
    } t_rx_item;

    logic                             i_clk;
    logic                             i_rst_n     = 1'b0;
    logic                             i_s_tvalid  = 1'b0;
    logic                             o_s_tready;
    logic [7:0]                       i_s_tdata   = '0;
    logic                             o_m_tvalid;
    logic                             i_m_tready  = 1'b0;
    logic [ps2md_pkg::TDATA_W-1:0]    o_m_tdata;
    logic [2:0]                       o_m_tuser;
    logic                             o_m_tlast;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [1:0]                       i_cfg_index = '0;
    logic [12:0]                      i_cfg_data  = '0;

    ps2_mouse_packet_decoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    t_rx_item     rx_items[$];
    t_mouse_event expected_events[$];
    int           src_idle_pct = 0;
    int           snk_idle_pct = 0;
    int           fail_total   = 0;
    int           quiet_cycles = 0;

    // Decoder model state, starting from the reset values.
    logic [1:0]   cfg_mode   = ps2md_pkg::MODE_STD;
    logic         cfg_clamp  = 1'b0;
    logic [12:0]  cfg_width  = 13'd640;
    logic [12:0]  cfg_height = 13'd480;
    logic [1:0]   frame_pos  = ps2md_pkg::BYTE_HDR;
    logic         sync_lost_once = 1'b0;
    logic [7:0]   x_move_byte = '0;
    longint       cursor_x   = 10;
    longint       cursor_y   = 10;
    int           scroll_v   = 0;
    int           scroll_h   = 0;
    logic [4:0]   button_bits = '0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void log_failure(input string msg);
        fail_total++;
        if (fail_total <= REPORT_MAX) begin
            $display("ERROR: %s", msg);
        end
    endfunction

    function automatic longint fit_screen(input longint v, input logic [12:0] size);
        longint top;
        top = longint'(size) - 1;
        if (v > top) begin
            v = top;
        end
        if (v < 0) begin
            v = 0;
        end
        return v;
    endfunction

    function automatic longint fit_pos_range(input longint v);
        longint hi;
        hi = (longint'(1) <<< (ps2md_pkg::POS_BITS - 1)) - 1;
        if (v > hi) begin
            v = hi;
        end else if (v < -hi - 1) begin
            v = -hi - 1;
        end
        return v;
    endfunction

    function automatic int fit_word(input int v);
        if (v > 32767) begin
            v = 32767;
        end else if (v < -32768) begin
            v = -32768;
        end
        return v;
    endfunction

    function automatic void push_event(input ps2md_pkg::t_kind kind, input logic [2:0] id,
                                       input logic signed [7:0] da,
                                       input logic signed [7:0] db);
        t_mouse_event e;
        e.ev.kind      = kind;
        e.ev.button_id = id;
        e.ev.delta_a   = da;
        e.ev.delta_b   = db;
        e.ev.pos_x     = cursor_x[15:0];
        e.ev.pos_y     = cursor_y[15:0];
        e.ev.wheel_v   = scroll_v[15:0];
        e.ev.wheel_h   = scroll_h[15:0];
        e.ev.buttons   = button_bits;
        e.last         = 1'b0;
        expected_events.push_back(e);
    endfunction

    function automatic void track_button(input logic pressed, input logic [2:0] id);
        if (button_bits[id] != pressed) begin
            button_bits[id] = pressed;
            push_event(pressed ? ps2md_pkg::KIND_DOWN : ps2md_pkg::KIND_UP, id, 8'sd0, 8'sd0);
        end
    endfunction

    function automatic void apply_scroll(input int v, input int h);
        if (v != 0 || h != 0) begin
            scroll_h = fit_word(scroll_h + h);
            scroll_v = fit_word(scroll_v + v);
            push_event(ps2md_pkg::KIND_WHEEL, ps2md_pkg::BTN_LEFT, 8'(v), 8'(h));
        end
    endfunction

    function automatic void decode_rx_byte(input logic [7:0] b);
        int                first_new;
        logic              wheel_mode;
        logic signed [7:0] dx;
        logic signed [7:0] dy;
        longint            nx;
        longint            ny;
        t_mouse_event      tail;
        first_new  = expected_events.size();
        wheel_mode = (cfg_mode == ps2md_pkg::MODE_WHEEL) || (cfg_mode == ps2md_pkg::MODE_FIVE);
        if (frame_pos == ps2md_pkg::BYTE_HDR && !b[3]) begin
            if (sync_lost_once) begin
                push_event(ps2md_pkg::KIND_SYNC, ps2md_pkg::BTN_LEFT, 8'sd0, 8'sd0);
            end else begin
                sync_lost_once = 1'b1;
            end
        end else begin
            case (frame_pos)
                ps2md_pkg::BYTE_HDR: begin
                    track_button(b[0], ps2md_pkg::BTN_LEFT);
                    track_button(b[1], ps2md_pkg::BTN_RIGHT);
                    track_button(b[2], ps2md_pkg::BTN_MIDDLE);
                end
                ps2md_pkg::BYTE_X: begin
                    x_move_byte = b;
                end
                ps2md_pkg::BYTE_Y: begin
                    dx = x_move_byte;
                    dy = 8'd0 - b;
                    if (dx != 0 || dy != 0) begin
                        nx = cursor_x + dx;
                        ny = cursor_y + dy;
                        if (cfg_clamp) begin
                            nx = fit_screen(nx, cfg_width);
                            ny = fit_screen(ny, cfg_height);
                        end
                        cursor_x = fit_pos_range(nx);
                        cursor_y = fit_pos_range(ny);
                        push_event(ps2md_pkg::KIND_MOVE, ps2md_pkg::BTN_LEFT, dx, dy);
                    end
                end
                default: begin
                    if (cfg_mode == ps2md_pkg::MODE_WHEEL) begin
                        apply_scroll(int'($signed(b)), 0);
                    end else if (cfg_mode == ps2md_pkg::MODE_FIVE) begin
                        case (b[3:0])
                            ps2md_pkg::NIB_H_NEG: apply_scroll(0, -1);
                            ps2md_pkg::NIB_V_NEG: apply_scroll(-1, 0);
                            ps2md_pkg::NIB_V_POS: apply_scroll(1, 0);
                            ps2md_pkg::NIB_H_POS: apply_scroll(0, 1);
                            default: ;
                        endcase
                        track_button(b[4], ps2md_pkg::BTN_FOURTH);
                        track_button(b[5], ps2md_pkg::BTN_FIFTH);
                    end
                end
            endcase
            frame_pos = (frame_pos == (wheel_mode ? ps2md_pkg::BYTE_EXT : ps2md_pkg::BYTE_Y))
                      ? ps2md_pkg::BYTE_HDR : frame_pos + 2'd1;
        end
        if (expected_events.size() > first_new) begin
            tail = expected_events.pop_back();
            tail.last = 1'b1;
            expected_events.push_back(tail);
        end
    endfunction

    function automatic string event_diffs(input t_mouse_event e, input t_mouse_event g);
        string s;
        s = "";
        if (g.ev.kind !== e.ev.kind)
            s = {s, $sformatf(" kind %0d/%0d", e.ev.kind, g.ev.kind)};
        if (g.ev.button_id !== e.ev.button_id)
            s = {s, $sformatf(" button_id %0d/%0d", e.ev.button_id, g.ev.button_id)};
        if (g.ev.delta_a !== e.ev.delta_a)
            s = {s, $sformatf(" delta_a %0d/%0d", e.ev.delta_a, g.ev.delta_a)};
        if (g.ev.delta_b !== e.ev.delta_b)
            s = {s, $sformatf(" delta_b %0d/%0d", e.ev.delta_b, g.ev.delta_b)};
        if (g.ev.pos_x !== e.ev.pos_x)
            s = {s, $sformatf(" pos_x %0d/%0d", e.ev.pos_x, g.ev.pos_x)};
        if (g.ev.pos_y !== e.ev.pos_y)
            s = {s, $sformatf(" pos_y %0d/%0d", e.ev.pos_y, g.ev.pos_y)};
        if (g.ev.wheel_v !== e.ev.wheel_v)
            s = {s, $sformatf(" wheel_v %0d/%0d", e.ev.wheel_v, g.ev.wheel_v)};
        if (g.ev.wheel_h !== e.ev.wheel_h)
            s = {s, $sformatf(" wheel_h %0d/%0d", e.ev.wheel_h, g.ev.wheel_h)};
        if (g.ev.buttons !== e.ev.buttons)
            s = {s, $sformatf(" buttons %0h/%0h", e.ev.buttons, g.ev.buttons)};
        if (g.last !== e.last)
            s = {s, $sformatf(" last %0b/%0b", e.last, g.last)};
        return s;
    endfunction

    // Byte driver: a byte marked hold is not offered until every expected event has arrived.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                decode_rx_byte(i_s_tdata);
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (rx_items.size() != 0
                        && !(rx_items[0].hold && expected_events.size() != 0)
                        && $urandom_range(99) >= src_idle_pct) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= rx_items[0].data;
                    void'(rx_items.pop_front());
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_mouse_event got;
        string        diffs;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got.ev.kind      = ps2md_pkg::t_kind'(o_m_tuser);
                got.ev.button_id = o_m_tdata[2:0];
                got.ev.delta_a   = o_m_tdata[10:3];
                got.ev.delta_b   = o_m_tdata[18:11];
                got.ev.pos_x     = o_m_tdata[34:19];
                got.ev.pos_y     = o_m_tdata[50:35];
                got.ev.wheel_v   = o_m_tdata[66:51];
                got.ev.wheel_h   = o_m_tdata[82:67];
                got.ev.buttons   = o_m_tdata[87:83];
                got.last         = o_m_tlast;
                if (expected_events.size() == 0) begin
                    log_failure($sformatf("event beat with none expected, kind %0d", o_m_tuser));
                end else begin
                    diffs = event_diffs(expected_events.pop_front(), got);
                    if (diffs != "") begin
                        log_failure({"event mismatch (expected/actual):", diffs});
                    end
                end
            end
            i_m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic void push_rx(input logic [7:0] d, input bit hold);
        t_rx_item it;
        it.data = d;
        it.hold = hold;
        rx_items.push_back(it);
    endfunction

    // The first byte of the sequence sits in the highest used byte of seq.
    function automatic void push_seq(input logic [8*16-1:0] seq, input int n);
        for (int i = 0; i < n; i++) begin
            push_rx(seq[8*(n-1-i) +: 8], 1'b0);
        end
    endfunction

    function automatic logic [7:0] pick_delta();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'h01;
            2: return 8'hFF;
            3: return 8'h7F;
            4: return 8'h80;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] pick_five_button_byte();
        logic [3:0] nib;
        case ($urandom_range(4))
            0: nib = ps2md_pkg::NIB_H_NEG;
            1: nib = ps2md_pkg::NIB_V_NEG;
            2: nib = ps2md_pkg::NIB_V_POS;
            3: nib = ps2md_pkg::NIB_H_POS;
            default: nib = 4'($urandom_range(15));
        endcase
        return {4'($urandom_range(15)), nib};
    endfunction

    // Mostly whole packets with random content; some stray bytes and cut-off packets.
    function automatic void queue_random(input int n, input logic [1:0] mode);
        int         sent;
        int         pkt_no;
        int         len;
        int         keep;
        logic [7:0] pkt[4];
        sent   = 0;
        pkt_no = 0;
        len    = (mode == ps2md_pkg::MODE_WHEEL || mode == ps2md_pkg::MODE_FIVE) ? 4 : 3;
        while (sent < n) begin
            if ($urandom_range(99) < 8) begin
                push_rx(8'($urandom_range(255)), 1'b0);
                sent++;
            end else begin
                pkt[0] = 8'($urandom_range(255)) | 8'h08;
                pkt[1] = pick_delta();
                pkt[2] = pick_delta();
                pkt[3] = (mode == ps2md_pkg::MODE_FIVE) ? pick_five_button_byte() : pick_delta();
                keep   = ($urandom_range(99) < 7) ? $urandom_range(len - 1, 1) : len;
                for (int i = 0; i < keep; i++) begin
                    push_rx(pkt[i], i == 0 && (pkt_no == 5 || $urandom_range(24) == 0));
                end
                sent += keep;
                pkt_no++;
            end
        end
    endfunction

    // Wheel-mode packets that push x and the vertical wheel up and y down in large steps.
    function automatic void queue_sweep(input int packets);
        for (int i = 0; i < packets; i++) begin
            push_rx(8'($urandom_range(255)) | 8'h08, 1'b0);
            push_rx(8'($urandom_range(127, 120)), 1'b0);
            push_rx(8'($urandom_range(127, 120)), 1'b0);
            push_rx(8'($urandom_range(127, 120)), 1'b0);
        end
    endfunction

    task automatic settle();
        while (rx_items.size() != 0 || i_s_tvalid || expected_events.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (idx)
            ps2md_pkg::CFG_MODE:  cfg_mode   = value[1:0];
            ps2md_pkg::CFG_CLAMP: cfg_clamp  = value[0];
            ps2md_pkg::CFG_WIDTH: cfg_width  = value;
            default:              cfg_height = value;
        endcase
    endtask

    task automatic configure(input logic [1:0] mode, input logic clamp,
                             input logic [12:0] width, input logic [12:0] height);
        write_reg(ps2md_pkg::CFG_MODE, 13'(mode));
        write_reg(ps2md_pkg::CFG_CLAMP, 13'(clamp));
        write_reg(ps2md_pkg::CFG_WIDTH, width);
        write_reg(ps2md_pkg::CFG_HEIGHT, height);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        src_idle_pct = 23;
        snk_idle_pct = 69;

        // Suppressed and reported bad first bytes, all buttons at once, extreme moves,
        // ignored overflow bits and a zero move, all with the reset settings.
        push_seq({8'h00, 8'h37, 8'h0F, 8'h7F, 8'h80, 8'h08, 8'h80, 8'h7F,
                  8'hF8, 8'h00, 8'h00}, 11);
        settle();
        configure(ps2md_pkg::MODE_WHEEL, 1'b0, 13'd640, 13'd480);
        // The second packet stops after three bytes so that the mode change below
        // leaves a fourth byte due in the three-byte mode.
        push_seq({8'h09, 8'h01, 8'hFF, 8'h80, 8'h0A, 8'h00, 8'h00}, 7);
        settle();
        configure(ps2md_pkg::MODE_STD, 1'b0, 13'd640, 13'd480);
        push_seq(8'h7F, 1);
        settle();
        configure(ps2md_pkg::MODE_FIVE, 1'b1, 13'd1, 13'd1);
        push_seq({8'h08, 8'h00, 8'h00, 8'h3E, 8'h08, 8'h05, 8'h00, 8'hCF}, 8);
        settle();

        configure(ps2md_pkg::MODE_STD, 1'b0, 13'd640, 13'd480);
        queue_random(35, ps2md_pkg::MODE_STD);
        settle();
        configure(ps2md_pkg::MODE_WHEEL, 1'b1, 13'd4096, 13'd4096);
        queue_random(35, ps2md_pkg::MODE_WHEEL);
        settle();

        src_idle_pct = 69;
        snk_idle_pct = 23;
        configure(ps2md_pkg::MODE_FIVE, 1'b1, 13'd1, 13'd1);
        queue_random(35, ps2md_pkg::MODE_FIVE);
        settle();
        configure(ps2md_pkg::MODE_FIVE, 1'b0, 13'd4096, 13'd1);
        queue_random(35, ps2md_pkg::MODE_FIVE);
        settle();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        configure(ps2md_pkg::MODE_WHEEL, 1'b0, 13'd640, 13'd480);
        queue_sweep(40);
        settle();
        configure(ps2md_pkg::MODE_WHEEL, 1'b1, 13'($urandom_range(4096, 1)),
                  13'($urandom_range(4096, 1)));
        queue_random(35, ps2md_pkg::MODE_WHEEL);
        settle();
        configure(ps2md_pkg::MODE_STD, 1'b1, 13'd4096, 13'd1);
        queue_random(25, ps2md_pkg::MODE_STD);
        settle();

        if (fail_total == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
